>>> hw/rtl/itr_pkg.sv
`timescale 1ns / 1ps

package itr_pkg;

  localparam int unsigned NumW = 13;
  localparam int unsigned LetW = 7;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned MaxLetters = 16;

  localparam logic [LetW-1:0] LetI = 7'd73;
  localparam logic [LetW-1:0] LetV = 7'd86;
  localparam logic [LetW-1:0] LetX = 7'd88;
  localparam logic [LetW-1:0] LetL = 7'd76;
  localparam logic [LetW-1:0] LetC = 7'd67;
  localparam logic [LetW-1:0] LetD = 7'd68;
  localparam logic [LetW-1:0] LetM = 7'd77;
  localparam logic [LetW-1:0] LetNone = 7'd0;

  // digit positions
  localparam logic [1:0] PosThou = 2'd0;
  localparam logic [1:0] PosHund = 2'd1;
  localparam logic [1:0] PosTens = 2'd2;
  localparam logic [1:0] PosUnit = 2'd3;

  // split entry handed from front to back
  typedef struct packed {
    logic       bad;
    logic [3:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] unit;
  } entry_t;

  function automatic logic [13:0] place_of(logic [1:0] pos);
    logic [13:0] p;
    case (pos)
      PosThou: p = 14'd1000;
      PosHund: p = 14'd100;
      PosTens: p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  // digit of rem at the given place: count of multiples not above rem
  function automatic logic [3:0] split_digit(logic [NumW-1:0] rem, logic [1:0] pos);
    logic [13:0] p;
    logic [3:0]  d;
    p = place_of(pos);
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, rem} >= 14'(k) * p) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

  function automatic logic [3:0] digit_len(logic [3:0] d, logic [1:0] pos);
    logic [3:0] len;
    if (pos == PosThou) begin
      len = d;
    end else begin
      case (d)
        4'd1, 4'd5: len = 4'd1;
        4'd2, 4'd4, 4'd6, 4'd9: len = 4'd2;
        4'd3, 4'd7: len = 4'd3;
        4'd8: len = 4'd4;
        default: len = 4'd0;
      endcase
    end
    return len;
  endfunction

  function automatic logic [LetW-1:0] digit_letter(logic [3:0] d, logic [3:0] j,
                                                   logic [1:0] pos);
    logic [LetW-1:0] one;
    logic [LetW-1:0] five;
    logic [LetW-1:0] ten;
    logic [LetW-1:0] let_o;
    case (pos)
      PosHund: begin
        one = LetC; five = LetD; ten = LetM;
      end
      PosTens: begin
        one = LetX; five = LetL; ten = LetC;
      end
      PosUnit: begin
        one = LetI; five = LetV; ten = LetX;
      end
      default: begin
        one = LetM; five = LetM; ten = LetM;
      end
    endcase
    if (pos == PosThou) begin
      let_o = one;
    end else if (d == 4'd9) begin
      let_o = (j == 4'd0) ? one : ten;
    end else if (d >= 4'd5) begin
      let_o = (j == 4'd0) ? five : one;
    end else if (d == 4'd4) begin
      let_o = (j == 4'd0) ? one : five;
    end else begin
      let_o = one;
    end
    return let_o;
  endfunction

endpackage

>>> hw/rtl/integer_to_roman_letters_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// input     in         push / full         number_i[12:0]
// result    out        empty / pop         letter_o[6:0], last_o, bad_value_o
//
// Front steps per number: take, three digit-split steps, hand-off to queue (a bad number skips the split).
// Back: a load step, then one letter per cycle unless a held result (pop low) stalls it.
// The back's single letter generator and its output register set the letter rate.
// rst_ni clears the control state asynchronously; the queue comes up empty.
// A held result (pop low) stalls the back; a full queue stalls the front.

module integer_to_roman_letters_unit #(
  parameter int unsigned MAX_VALUE = 5000
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [itr_pkg::NumW-1:0] number_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [itr_pkg::LetW-1:0] letter_o,
  output logic                     last_o,
  output logic                     bad_value_o
);

  logic            busy;
  logic            f_wr, f_full, f_rd, f_empty;
  itr_pkg::entry_t f_wdata, f_rdata;
  logic            pop_ok;

  // full while the front is still splitting or queueing the previous number
  assign full   = busy;
  assign pop_ok = pop && !empty;

  itr_front #(
    .MAX_VALUE (MAX_VALUE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .busy_o      (busy),
    .number_i    (number_i),
    .wr_o        (f_wr),
    .wdata_o     (f_wdata),
    .fifo_full_i (f_full)
  );

  // short queue of split numbers decouples front from back
  itr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_wr),
    .wdata_i (f_wdata),
    .full_o  (f_full),
    .rd_i    (f_rd),
    .rdata_o (f_rdata),
    .empty_o (f_empty)
  );

  itr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (f_empty),
    .rdata_i      (f_rdata),
    .rd_o         (f_rd),
    .empty_o      (empty),
    .pop_i        (pop_ok),
    .letter_o     (letter_o),
    .last_o       (last_o),
    .bad_value_o  (bad_value_o)
  );

endmodule

>>> hw/rtl/itr_front.sv
`timescale 1ns / 1ps

module itr_front #(
  parameter int unsigned MAX_VALUE = 5000
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     busy_o,
  input  logic [itr_pkg::NumW-1:0] number_i,
  output logic                     wr_o,
  output itr_pkg::entry_t          wdata_o,
  input  logic                     fifo_full_i
);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_SPLIT = 3'b010,
    F_PUSH  = 3'b100
  } fstate_e;

  localparam logic [itr_pkg::NumW-1:0] MaxVal = itr_pkg::NumW'(MAX_VALUE);

  fstate_e                   state_q, state_d;
  logic [1:0]                pos_q, pos_d;
  logic [itr_pkg::NumW-1:0]  rem_q, rem_d;
  itr_pkg::entry_t           ent_q, ent_d;
  logic [3:0]                dig;
  logic [13:0]               sub;

  assign dig = itr_pkg::split_digit(rem_q, pos_q);
  assign sub = 14'(dig) * itr_pkg::place_of(pos_q);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    ent_d   = ent_q;
    wr_o    = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          rem_d     = number_i;
          pos_d     = itr_pkg::PosThou;
          ent_d.bad = (number_i == '0) || (number_i > MaxVal);
          state_d   = ent_d.bad ? F_PUSH : F_SPLIT;
        end
      end
      F_SPLIT: begin
        rem_d = rem_q - sub[itr_pkg::NumW-1:0];
        pos_d = pos_q + 2'd1;
        case (pos_q)
          itr_pkg::PosThou: ent_d.thou = dig;
          itr_pkg::PosHund: ent_d.hund = dig;
          default: begin
            ent_d.tens = dig;
            ent_d.unit = rem_d[3:0];
            state_d    = F_PUSH;
          end
        endcase
      end
      F_PUSH: begin
        if (!fifo_full_i) begin
          wr_o    = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      pos_q   <= itr_pkg::PosThou;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    ent_q <= ent_d;
  end

  assign busy_o  = (state_q != F_IDLE);
  assign wdata_o = ent_q;

endmodule

>>> hw/rtl/itr_fifo.sv
`timescale 1ns / 1ps

module itr_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  itr_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output itr_pkg::entry_t rdata_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = $clog2(itr_pkg::FifoDepth);

  itr_pkg::entry_t mem_q [itr_pkg::FifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(itr_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (rd_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/itr_back.sv
`timescale 1ns / 1ps

module itr_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fifo_empty_i,
  input  itr_pkg::entry_t          rdata_i,
  output logic                     rd_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic [itr_pkg::LetW-1:0] letter_o,
  output logic                     last_o,
  output logic                     bad_value_o
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_e;

  bstate_e                  state_q, state_d;
  itr_pkg::entry_t          ent_q;
  logic [1:0]               pos_q, pos_d, first_pos, next_pos;
  logic [3:0]               j_q, j_d, n_q, n_d;
  logic                     ovld_q;
  logic [itr_pkg::LetW-1:0] let_q;
  logic                     last_q, bad_q;
  logic [3:0]               cur_d, len;
  logic                     rest_zero, digit_end, run_last, step_en;

  always_comb begin
    case (pos_q)
      itr_pkg::PosThou: cur_d = ent_q.thou;
      itr_pkg::PosHund: cur_d = ent_q.hund;
      itr_pkg::PosTens: cur_d = ent_q.tens;
      default:          cur_d = ent_q.unit;
    endcase
  end

  // next non-empty digit after the current one
  always_comb begin
    case (pos_q)
      itr_pkg::PosThou: begin
        rest_zero = (ent_q.hund == '0) && (ent_q.tens == '0) && (ent_q.unit == '0);
        next_pos  = (ent_q.hund != '0) ? itr_pkg::PosHund :
                    (ent_q.tens != '0) ? itr_pkg::PosTens : itr_pkg::PosUnit;
      end
      itr_pkg::PosHund: begin
        rest_zero = (ent_q.tens == '0) && (ent_q.unit == '0);
        next_pos  = (ent_q.tens != '0) ? itr_pkg::PosTens : itr_pkg::PosUnit;
      end
      itr_pkg::PosTens: begin
        rest_zero = (ent_q.unit == '0);
        next_pos  = itr_pkg::PosUnit;
      end
      default: begin
        rest_zero = 1'b1;
        next_pos  = itr_pkg::PosUnit;
      end
    endcase
  end

  assign first_pos = (rdata_i.thou != '0) ? itr_pkg::PosThou :
                     (rdata_i.hund != '0) ? itr_pkg::PosHund :
                     (rdata_i.tens != '0) ? itr_pkg::PosTens : itr_pkg::PosUnit;

  assign len       = itr_pkg::digit_len(cur_d, pos_q);
  assign digit_end = ((j_q + 4'd1) == len);
  assign run_last  = ent_q.bad || (digit_end && rest_zero) ||
                     (n_q == 4'(itr_pkg::MaxLetters - 1));
  assign step_en   = (state_q == B_RUN) && (!ovld_q || pop_i);
  assign rd_o      = (state_q == B_IDLE) && !fifo_empty_i;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    j_d     = j_q;
    n_d     = n_q;
    case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          pos_d   = first_pos;
          j_d     = '0;
          n_d     = '0;
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (step_en) begin
          n_d = n_q + 4'd1;
          if (run_last) begin
            state_d = B_IDLE;
          end else if (digit_end) begin
            pos_d = next_pos;
            j_d   = '0;
          end else begin
            j_d = j_q + 4'd1;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (step_en) begin
        ovld_q <= 1'b1;
      end else if (pop_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    j_q   <= j_d;
    n_q   <= n_d;
    if (rd_o) begin
      ent_q <= rdata_i;
    end
    if (step_en) begin
      let_q  <= ent_q.bad ? itr_pkg::LetNone : itr_pkg::digit_letter(cur_d, j_q, pos_q);
      last_q <= run_last;
      bad_q  <= ent_q.bad;
    end
  end

  assign empty_o     = !ovld_q;
  assign letter_o    = let_q;
  assign last_o      = last_q;
  assign bad_value_o = bad_q;

endmodule

>>> hw/rtl/itr_checker.sv
`timescale 1ns / 1ps

module itr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     empty,
  input logic                     pop,
  input logic [itr_pkg::LetW-1:0] letter_o,
  input logic                     last_o,
  input logic                     bad_value_o
);

  // an error result stands alone
  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_value_o) |-> last_o)
    else $error("error result without last");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bad_value_o) |-> (letter_o == itr_pkg::LetNone))
    else $error("error result carries a letter");

  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !bad_value_o) |->
      (letter_o == itr_pkg::LetI || letter_o == itr_pkg::LetV ||
       letter_o == itr_pkg::LetX || letter_o == itr_pkg::LetL ||
       letter_o == itr_pkg::LetC || letter_o == itr_pkg::LetD ||
       letter_o == itr_pkg::LetM))
    else $error("letter is not a numeral");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(letter_o) && $stable(last_o)))
    else $error("waiting result changed");

endmodule

bind integer_to_roman_letters_unit itr_checker u_itr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .letter_o    (letter_o),
  .last_o      (last_o),
  .bad_value_o (bad_value_o)
);

>>> sim/tb_integer_to_roman_letters_unit.sv
`timescale 1ns / 1ps

module tb_integer_to_roman_letters_unit;

  localparam int unsigned TopValue = 5000;   // matches the default MAX_VALUE of the unit
  localparam int unsigned RandItems = 395;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned HoldCycles = 150;  // the one long receiver hold-off
  localparam int unsigned HoldAtLetter = 1200;
  localparam int unsigned DrainAtA = 25;     // sender waits for an empty scoreboard here
  localparam int unsigned DrainAtB = 250;

  typedef struct {
    logic [itr_pkg::LetW-1:0] letter;
    logic                     is_last;
    logic                     bad;
  } letter_rec_t;

  // receiver pop patterns
  typedef enum logic [1:0] {
    RxFree,    // pop every cycle
    RxCoin,    // pop half the time
    RxBeat,    // pop unless rx_beat is a multiple of four
    RxSparse   // pop one cycle in four, on average
  } rx_mode_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  logic [itr_pkg::NumW-1:0] number_i = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [itr_pkg::LetW-1:0] letter_o;
  logic                     last_o;
  logic                     bad_value_o;

  logic [itr_pkg::NumW-1:0] numbers_to_send[$];
  letter_rec_t              expected_letters[$];
  int unsigned              run_len;
  int unsigned              mismatch_cnt = 0;
  int unsigned              cycle_cnt = 0;

  integer_to_roman_letters_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .number_i   (number_i),
    .empty      (empty),
    .pop        (pop),
    .letter_o   (letter_o),
    .last_o     (last_o),
    .bad_value_o(bad_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Roman letter prediction
  // --------------------------------------------------------------------------

  // one letter onto the scoreboard; a run is capped at MaxLetters letters
  function automatic void add_letter(logic [itr_pkg::LetW-1:0] ch);
    letter_rec_t rec;
    if (run_len < itr_pkg::MaxLetters) begin
      rec.letter  = ch;
      rec.is_last = 1'b0;
      rec.bad     = 1'b0;
      expected_letters.push_back(rec);
      run_len++;
    end
  endfunction

  // one decimal digit in subtractive form: 9 -> one+ten, 5..8 -> five+ones,
  // 4 -> one+five, else plain repeats (zero gives nothing)
  function automatic void add_digit(int unsigned d, logic [itr_pkg::LetW-1:0] one,
                                    logic [itr_pkg::LetW-1:0] five,
                                    logic [itr_pkg::LetW-1:0] ten);
    if (d == 9) begin
      add_letter(one);
      add_letter(ten);
    end else if (d >= 5) begin
      add_letter(five);
      for (int k = 5; k < d; k++) add_letter(one);
    end else if (d == 4) begin
      add_letter(one);
      add_letter(five);
    end else begin
      for (int k = 0; k < d; k++) add_letter(one);
    end
  endfunction

  // expected run of letters for one accepted number
  function automatic void predict_numeral(logic [itr_pkg::NumW-1:0] num);
    int unsigned v;
    letter_rec_t rec;
    v = num;
    run_len = 0;
    if (v == 0 || v > TopValue) begin
      // out of range: a single flagged result with letter zero
      rec.letter  = itr_pkg::LetNone;
      rec.is_last = 1'b1;
      rec.bad     = 1'b1;
      expected_letters.push_back(rec);
    end else begin
      // thousands as plain repeated M, even for four and five thousand
      for (int k = 0; k < v / 1000; k++) add_letter(itr_pkg::LetM);
      add_digit((v / 100) % 10, itr_pkg::LetC, itr_pkg::LetD, itr_pkg::LetM);
      add_digit((v / 10) % 10, itr_pkg::LetX, itr_pkg::LetL, itr_pkg::LetC);
      add_digit(v % 10, itr_pkg::LetI, itr_pkg::LetV, itr_pkg::LetX);
      expected_letters[expected_letters.size() - 1].is_last = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of pushes with random gaps, two pauses for a full drain
  // --------------------------------------------------------------------------

  int unsigned burst_left = 8;
  int unsigned gap_left = 0;
  int unsigned sent_cnt = 0;
  bit          drain_wait = 1'b0;

  always @(posedge clk_i) begin
    bit want;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      want = 1'b0;
      // input transfer at this edge
      if (push && !full) begin
        predict_numeral(number_i);
        void'(numbers_to_send.pop_front());
        sent_cnt++;
        if (sent_cnt == DrainAtA || sent_cnt == DrainAtB) drain_wait = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then straight on, mostly a random gap before the next burst
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(20);
          burst_left = $urandom_range(1, 30);
        end
      end
      if (drain_wait) begin
        if (expected_letters.size() == 0) drain_wait = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (numbers_to_send.size() > 0) begin
        want = 1'b1;
      end
      push <= want;
      if (want) number_i <= numbers_to_send[0];
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: result checking and the receiver's own stall pattern
  // --------------------------------------------------------------------------

  rx_mode_e    rx_mode = RxFree;
  int unsigned rx_mode_left = 0;
  int unsigned rx_beat = 0;
  int unsigned hold_left = 0;
  int unsigned letters_seen = 0;

  always @(posedge clk_i) begin
    letter_rec_t exp_rec;
    bit want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      // result transfer at this edge
      if (pop && !empty) begin
        letters_seen++;
        if (letters_seen == HoldAtLetter) hold_left = HoldCycles;
        if (expected_letters.size() == 0) begin
          $display("%0t: unexpected result, expected none got letter %0d last %0b bad %0b",
                   $time, letter_o, last_o, bad_value_o);
          mismatch_cnt++;
        end else begin
          exp_rec = expected_letters.pop_front();
          if (letter_o !== exp_rec.letter) begin
            $display("%0t: letter mismatch, expected %0d got %0d",
                     $time, exp_rec.letter, letter_o);
            mismatch_cnt++;
          end
          if (last_o !== exp_rec.is_last) begin
            $display("%0t: last mismatch, expected %0b got %0b",
                     $time, exp_rec.is_last, last_o);
            mismatch_cnt++;
          end
          if (bad_value_o !== exp_rec.bad) begin
            $display("%0t: bad_value mismatch, expected %0b got %0b",
                     $time, exp_rec.bad, bad_value_o);
            mismatch_cnt++;
          end
        end
      end
      // pick a fresh pattern now and then
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(3));
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      rx_beat++;
      if (hold_left > 0) begin
        // long hold-off: the unit fills and must push back on its input
        hold_left--;
        want = 1'b0;
      end else begin
        case (rx_mode)
          RxFree:   want = 1'b1;
          RxCoin:   want = 1'($urandom_range(1));
          RxBeat:   want = (rx_beat % 4) != 0;
          default:  want = ($urandom_range(3) == 0);
        endcase
      end
      pop <= want;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------

  initial begin
    int unsigned pick;
    // directed: range edges, every subtractive form, longest run, errors
    numbers_to_send = '{13'd0, 13'd1, 13'd3, 13'd4, 13'd5, 13'd8, 13'd9, 13'd10,
                        13'd40, 13'd49, 13'd90, 13'd99, 13'd400, 13'd444, 13'd900,
                        13'd999, 13'd1000, 13'd1994, 13'd3999, 13'd4000, 13'd4888,
                        13'd5000, 13'd5001, 13'd8191, 13'd3888};
    for (int i = 0; i < RandItems; i++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        numbers_to_send.push_back(itr_pkg::NumW'($urandom_range(1, TopValue)));
      end else if (pick < 78) begin
        numbers_to_send.push_back(itr_pkg::NumW'($urandom_range(4000, TopValue)));
      end else if (pick < 90) begin
        numbers_to_send.push_back(itr_pkg::NumW'($urandom_range((1 << itr_pkg::NumW) - 1)));
      end else if (pick < 93) begin
        numbers_to_send.push_back('0);
      end else begin
        numbers_to_send.push_back(
          itr_pkg::NumW'($urandom_range(TopValue + 1, (1 << itr_pkg::NumW) - 1)));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_to_send.size() > 0) @(posedge clk_i);
    while (expected_letters.size() > 0) @(posedge clk_i);
    // room for any stray result to show up
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> integer_to_roman_letters_unit.f
hw/rtl/itr_pkg.sv
hw/rtl/itr_front.sv
hw/rtl/itr_fifo.sv
hw/rtl/itr_back.sv
hw/rtl/integer_to_roman_letters_unit.sv
hw/rtl/itr_checker.sv
sim/tb_integer_to_roman_letters_unit.sv
